// ===== rtl/cfp_pkg.sv =====
// Shared types and constants of the command frame parser.
package cfp_pkg;

  // Default frame length limit, in bytes
  localparam int FRAME_LIMIT_DEFAULT = 80;

  // Widths
  localparam int BYTE_W = 8;
  localparam int POS_W  = 7;
  localparam int ACC_W  = 32;

  // Framing characters
  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_POINT   = 8'h2E;
  localparam logic [7:0] CH_C       = 8'h63;
  localparam logic [7:0] CH_U       = 8'h75;
  localparam logic [7:0] CH_D       = 8'h64;
  localparam logic [7:0] DIGIT_BASE = 8'h30;

  // Start kind codes
  localparam logic [1:0] KIND_DOLLAR  = 2'd0;
  localparam logic [1:0] KIND_PERCENT = 2'd1;
  localparam logic [1:0] KIND_AMP     = 2'd2;

  // One byte held in the input register
  typedef struct packed {
    logic             valid;
    logic [BYTE_W-1:0] data;
  } cfp_word_t;

  // One decoded frame result
  typedef struct packed {
    logic [1:0]              start_kind;
    logic [7:0]              mode_code;
    logic                    center_valid;
    logic [15:0]             center_value;
    logic                    circle_valid;
    logic [7:0]              circle_count;
    logic                    angle_up_valid;
    logic                    angle_down_valid;
    logic signed [ACC_W-1:0] angle_tenths;
  } cfp_result_t;

endpackage

// ===== rtl/cfp_in_stage.sv =====
// Input register of the command frame parser.
module cfp_in_stage (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [cfp_pkg::BYTE_W-1:0] s_tdata,   // rx_byte[7:0]
  input  logic                      step,
  output cfp_pkg::cfp_word_t        word
);

  logic                       in_valid;
  logic [cfp_pkg::BYTE_W-1:0] in_byte;

  // Free when empty or when the held byte is consumed this cycle
  assign s_tready = !in_valid || step;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (step) begin
      in_valid <= 1'b0;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  assign word.valid = in_valid;
  assign word.data  = in_byte;

endmodule

// ===== rtl/cfp_core.sv =====
// Frame state, accumulators and result decode of the command frame parser.
module cfp_core #(
  parameter int FRAME_LIMIT = cfp_pkg::FRAME_LIMIT_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      step,
  input  logic [cfp_pkg::BYTE_W-1:0] rx_byte,
  output logic                      emit,
  output cfp_pkg::cfp_result_t      result
);

  localparam int AW = cfp_pkg::ACC_W;
  localparam int WW = AW + 5;

  // Saturate a wide signed value to the accumulator width
  function automatic logic signed [AW-1:0] sat_acc(input logic signed [WW-1:0] v);
    logic signed [WW-1:0] vmax;
    logic signed [WW-1:0] vmin;
    vmax = WW'({1'b0, {(AW-1){1'b1}}});
    vmin = -vmax - WW'(1);
    if (v > vmax) begin
      return {1'b0, {(AW-1){1'b1}}};
    end else if (v < vmin) begin
      return {1'b1, {(AW-1){1'b0}}};
    end
    return v[AW-1:0];
  endfunction

  // State registers
  logic                       frame_open, frame_open_next;
  logic [cfp_pkg::POS_W-1:0]  byte_position, byte_position_next;
  logic [7:0]                 start_byte, start_byte_next;
  logic [7:0]                 second_byte, second_byte_next;
  logic [7:0]                 third_byte, third_byte_next;
  logic [7:0]                 fourth_byte, fourth_byte_next;
  logic [7:0]                 count_acc, count_acc_next;
  logic signed [AW-1:0]       int_acc, int_acc_next;
  logic signed [AW-1:0]       frac_acc, frac_acc_next;
  logic                       after_point, after_point_next;

  logic                       is_start;
  logic                       open_eff;
  logic [cfp_pkg::POS_W-1:0]  pos_eff;
  logic [7:0]                 cnt_eff;
  logic signed [AW-1:0]       int_eff;
  logic signed [AW-1:0]       frac_eff;
  logic                       pt_eff;
  logic                       is_hash;
  logic                       do_acc;
  logic signed [WW-1:0]       digit;
  logic signed [WW-1:0]       int_ext;
  logic signed [WW-1:0]       frac_ext;
  logic signed [WW-1:0]       int_x10;
  logic [cfp_pkg::POS_W-1:0]  pos_inc;
  logic                       up, dn;

  // Next state and accumulation
  always_comb begin
    is_start = (rx_byte == cfp_pkg::CH_DOLLAR) || (rx_byte == cfp_pkg::CH_PERCENT)
            || (rx_byte == cfp_pkg::CH_AMP);
    is_hash  = (rx_byte == cfp_pkg::CH_HASH);
    open_eff = is_start || frame_open;
    pos_eff  = is_start ? '0 : byte_position;
    cnt_eff  = is_start ? '0 : count_acc;
    int_eff  = is_start ? '0 : int_acc;
    frac_eff = is_start ? '0 : frac_acc;
    pt_eff   = is_start ? 1'b0 : after_point;

    // Frame byte capture
    start_byte_next  = start_byte;
    second_byte_next = second_byte;
    third_byte_next  = third_byte;
    fourth_byte_next = fourth_byte;
    if (open_eff) begin
      case (pos_eff)
        7'd0:    start_byte_next  = rx_byte;
        7'd1:    second_byte_next = rx_byte;
        7'd2:    third_byte_next  = rx_byte;
        7'd3:    fourth_byte_next = rx_byte;
        default: ;
      endcase
    end

    emit   = open_eff && is_hash;
    do_acc = open_eff && !is_hash && (pos_eff >= 7'd2);

    // Accumulators
    digit    = WW'(signed'({1'b0, rx_byte})) - WW'(signed'({1'b0, cfp_pkg::DIGIT_BASE}));
    int_ext  = WW'(int_eff);
    frac_ext = WW'(frac_eff);
    int_x10  = (int_ext <<< 3) + (int_ext <<< 1);

    count_acc_next   = cnt_eff;
    int_acc_next     = int_eff;
    frac_acc_next    = frac_eff;
    after_point_next = pt_eff;
    if (do_acc) begin
      count_acc_next = 8'((cnt_eff << 3) + (cnt_eff << 1) + rx_byte - cfp_pkg::DIGIT_BASE);
      if (pt_eff) begin
        frac_acc_next = sat_acc(frac_ext + digit);
      end
      if (rx_byte == cfp_pkg::CH_POINT) begin
        after_point_next = 1'b1;
      end else if (!pt_eff) begin
        int_acc_next = sat_acc(int_x10 + digit);
      end
    end

    // Position counter and frame limit
    pos_inc            = pos_eff + 7'd1;
    byte_position_next = pos_inc;
    frame_open_next    = open_eff && !is_hash;
    if (pos_inc >= cfp_pkg::POS_W'(FRAME_LIMIT)) begin
      byte_position_next = '0;
      frame_open_next    = 1'b0;
    end
  end

  // Result decode from the bytes as they stand after this capture
  always_comb begin
    up = (start_byte_next == cfp_pkg::CH_AMP) && (second_byte_next == cfp_pkg::CH_U);
    dn = (start_byte_next == cfp_pkg::CH_AMP) && (second_byte_next == cfp_pkg::CH_D);
    if (start_byte_next == cfp_pkg::CH_PERCENT) begin
      result.start_kind = cfp_pkg::KIND_PERCENT;
    end else if (start_byte_next == cfp_pkg::CH_AMP) begin
      result.start_kind = cfp_pkg::KIND_AMP;
    end else begin
      result.start_kind = cfp_pkg::KIND_DOLLAR;
    end
    result.mode_code    = second_byte_next - cfp_pkg::DIGIT_BASE;
    result.center_valid = (start_byte_next == cfp_pkg::CH_PERCENT);
    result.center_value = result.center_valid ? {fourth_byte_next, third_byte_next} : 16'd0;
    result.circle_valid = (second_byte_next == cfp_pkg::CH_C);
    result.circle_count = result.circle_valid ? cnt_eff : 8'd0;
    result.angle_up_valid   = up;
    result.angle_down_valid = dn;
    result.angle_tenths = (up || dn) ? sat_acc(int_x10 + frac_ext) : '0;
  end

  // State update on each consumed byte
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open    <= 1'b0;
      byte_position <= '0;
      start_byte    <= '0;
      second_byte   <= '0;
      third_byte    <= '0;
      fourth_byte   <= '0;
      count_acc     <= '0;
      int_acc       <= '0;
      frac_acc      <= '0;
      after_point   <= 1'b0;
    end else if (step) begin
      frame_open    <= frame_open_next;
      byte_position <= byte_position_next;
      start_byte    <= start_byte_next;
      second_byte   <= second_byte_next;
      third_byte    <= third_byte_next;
      fourth_byte   <= fourth_byte_next;
      count_acc     <= count_acc_next;
      int_acc       <= int_acc_next;
      frac_acc      <= frac_acc_next;
      after_point   <= after_point_next;
    end
  end

endmodule

// ===== rtl/cfp_out_stage.sv =====
// Result register of the command frame parser.
module cfp_out_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  cfp_pkg::cfp_result_t result,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [63:0]          m_tdata,  // mode_code, center_value, circle_count, angle_tenths
  output logic [5:0]           m_tuser   // start_kind[1:0], center_valid, circle_valid,
                                         // angle_up_valid, angle_down_valid
);

  logic                 out_valid;
  cfp_pkg::cfp_result_t held;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {held.angle_tenths, held.circle_count, held.center_value, held.mode_code};
  assign m_tuser  = {held.angle_down_valid, held.angle_up_valid, held.circle_valid,
                     held.center_valid, held.start_kind};

endmodule

// ===== rtl/command_frame_parser.sv =====
// Top level of the command frame parser.
//
// Usage:
//   Slave channel s_* carries received bytes, one word per byte, in s_tdata.
//   Master channel m_* carries one decoded frame per word: numeric fields in
//   m_tdata and the start kind and field flags in m_tuser.
//   A frame opens on '$', '%' or '&' and closes on '#'; the closing byte
//   produces one result word. Other bytes produce nothing.
//   A counter reset by each start byte drops a frame after FRAME_LIMIT bytes.
// Timing:
//   One byte per cycle, except while a closing byte waits for the output
//   register. An accepted byte sits in the input register, is decoded there,
//   and its result is registered in the output register behind m_tvalid.
// Stall:
//   A waiting result holds in the output register; bytes that produce no
//   result keep flowing. A closing byte waits in the input register until the
//   result register frees, and s_tready drops while it waits.
// Reset:
//   rst (synchronous) empties both registers, closes the frame and zeroes
//   the stored frame bytes and accumulators.
module command_frame_parser #(
  parameter int FRAME_LIMIT = cfp_pkg::FRAME_LIMIT_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // rx_byte[7:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // mode_code[7:0], center_value[23:8],
                                 // circle_count[31:24], angle_tenths[63:32]
  output logic [5:0]  m_tuser    // start_kind[1:0], center_valid[2], circle_valid[3],
                                 // angle_up_valid[4], angle_down_valid[5]
);

  cfp_pkg::cfp_word_t   word;
  cfp_pkg::cfp_result_t result;
  logic                 emit;
  logic                 step;

  // Consume the held byte unless its result has nowhere to go
  assign step = word.valid && (!emit || !m_tvalid || m_tready);

  cfp_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .step     (step),
    .word     (word)
  );

  cfp_core #(
    .FRAME_LIMIT (FRAME_LIMIT)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .rx_byte (word.data),
    .emit    (emit),
    .result  (result)
  );

  cfp_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (step && emit),
    .result   (result),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

`ifndef ASSERT_OFF
  // A new result never overwrites one that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (step && emit) |-> (!m_tvalid || m_tready))
    else $error("result register overwritten");

  // A result appears only after a closing byte was consumed
  a_rise_from_step: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(step && emit))
    else $error("result without closing byte");

  // A byte waiting in the input register keeps its value
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (word.valid && !step) |=> (word.valid && $stable(word.data)))
    else $error("held input byte changed");

  // Angle flags only come with an ampersand frame
  a_angle_kind: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser[4] || m_tuser[5])) |-> (m_tuser[1:0] == cfp_pkg::KIND_AMP))
    else $error("angle flag on wrong frame kind");
`endif

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for command_frame_parser: byte stream in, decoded frames out.
`timescale 1ns / 100ps

module tb_top;

  localparam int FRAME_LIMIT  = cfp_pkg::FRAME_LIMIT_DEFAULT;
  localparam int RANDOM_BYTES = 1800;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 300;

  // Predicts decoded frames from the accepted byte stream and checks the output words
  class frame_result_scoreboard;
    bit                   frame_open;
    bit [6:0]             byte_pos;
    bit [7:0]             start_b, mode_b, third_b, fourth_b;
    bit [7:0]             count_acc;
    int                   int_acc;
    int                   frac_acc;
    bit                   after_point;
    int                   limit;
    int                   errors;
    cfp_pkg::cfp_result_t frames_due[$];

    function new(int frame_limit);
      limit = frame_limit;
      errors = 0;
      frame_open = 1'b0;
      byte_pos = '0;
      start_b = '0;
      mode_b = '0;
      third_b = '0;
      fourth_b = '0;
      clear_sums();
    endfunction

    function void clear_sums();
      count_acc = '0;
      int_acc = 0;
      frac_acc = 0;
      after_point = 1'b0;
    endfunction

    function int sat32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return int'(v);
    endfunction

    // Value parsing of one body byte
    function void add_body_byte(bit [7:0] b);
      longint digit;
      digit = b;
      digit = digit - 48;
      count_acc = count_acc * 8'd10 + b - cfp_pkg::DIGIT_BASE;
      if (after_point)
        frac_acc = sat32(longint'(frac_acc) + digit);
      if (b == cfp_pkg::CH_POINT)
        after_point = 1'b1;
      else if (!after_point)
        int_acc = sat32(longint'(int_acc) * 10 + digit);
    endfunction

    // Called once per accepted input word
    function void note_rx_byte(bit [7:0] b);
      cfp_pkg::cfp_result_t r;
      bit up, down;
      if (b == cfp_pkg::CH_DOLLAR || b == cfp_pkg::CH_PERCENT || b == cfp_pkg::CH_AMP) begin
        frame_open = 1'b1;
        byte_pos = '0;
        clear_sums();
      end
      if (frame_open) begin
        case (byte_pos)
          7'd0: start_b = b;
          7'd1: mode_b = b;
          7'd2: third_b = b;
          7'd3: fourth_b = b;
          default: ;
        endcase
        if (b == cfp_pkg::CH_HASH) begin
          up = (start_b == cfp_pkg::CH_AMP) && (mode_b == cfp_pkg::CH_U);
          down = (start_b == cfp_pkg::CH_AMP) && (mode_b == cfp_pkg::CH_D);
          r = '0;
          if (start_b == cfp_pkg::CH_PERCENT) r.start_kind = cfp_pkg::KIND_PERCENT;
          else if (start_b == cfp_pkg::CH_AMP) r.start_kind = cfp_pkg::KIND_AMP;
          else r.start_kind = cfp_pkg::KIND_DOLLAR;
          r.mode_code = mode_b - cfp_pkg::DIGIT_BASE;
          r.center_valid = (start_b == cfp_pkg::CH_PERCENT);
          r.center_value = r.center_valid ? {fourth_b, third_b} : 16'd0;
          r.circle_valid = (mode_b == cfp_pkg::CH_C);
          r.circle_count = r.circle_valid ? count_acc : 8'd0;
          r.angle_up_valid = up;
          r.angle_down_valid = down;
          r.angle_tenths = (up || down) ? sat32(longint'(int_acc) * 10 + frac_acc) : 0;
          frames_due.push_back(r);
          frame_open = 1'b0;
        end else if (byte_pos >= 2) begin
          add_body_byte(b);
        end
      end
      byte_pos = byte_pos + 7'd1;
      if (byte_pos >= limit) begin
        byte_pos = '0;
        frame_open = 1'b0;
      end
    endfunction

    function void compare_field(string field, longint want, longint got);
      if (want != got) begin
        errors++;
        if (errors <= 10)
          $display("mismatch in %s: expected %0d, got %0d", field, want, got);
      end
    endfunction

    // Called once per accepted output word
    function void check_decoded(logic [63:0] data, logic [5:0] user);
      cfp_pkg::cfp_result_t want;
      if (frames_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result word: tdata %h tuser %h", data, user);
        return;
      end
      want = frames_due.pop_front();
      compare_field("start_kind", want.start_kind, user[1:0]);
      compare_field("mode_code", want.mode_code, data[7:0]);
      compare_field("center_valid", want.center_valid, user[2]);
      compare_field("center_value", want.center_value, data[23:8]);
      compare_field("circle_valid", want.circle_valid, user[3]);
      compare_field("circle_count", want.circle_count, data[31:24]);
      compare_field("angle_up_valid", want.angle_up_valid, user[4]);
      compare_field("angle_down_valid", want.angle_down_valid, user[5]);
      compare_field("angle_tenths", want.angle_tenths, $signed(data[63:32]));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;     // rx_byte[7:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;          // mode_code[7:0], center_value[23:8],
                                 // circle_count[31:24], angle_tenths[63:32]
  logic [5:0]  m_tuser;          // start_kind[1:0], center_valid[2], circle_valid[3],
                                 // angle_up_valid[4], angle_down_valid[5]

  frame_result_scoreboard sb;
  logic [7:0] byte_queue[$];
  int         sent_count = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         cycle_count = 0;
  bit         hold_go = 1'b0;
  logic       hold_off = 1'b0;

  command_frame_parser #(.FRAME_LIMIT(FRAME_LIMIT)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #2 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("command_frame_parser verification failed");
      $finish;
    end
  end

  // Receiver: random stalls, plus the long hold-off
  always @(posedge clk) begin
    if (hold_off)
      m_tready <= 1'b0;
    else
      m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Long receiver hold-off while the sender keeps going
  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Output monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_decoded(m_tdata, m_tuser);
  end

  function automatic bit is_special(logic [7:0] v);
    return v == cfp_pkg::CH_DOLLAR || v == cfp_pkg::CH_PERCENT || v == cfp_pkg::CH_AMP
        || v == cfp_pkg::CH_HASH;
  endfunction

  // Body byte by flavor: digits and points, low bytes, high bytes or any non-special
  function automatic logic [7:0] body_byte(int flavor);
    logic [7:0] v;
    case (flavor)
      0: v = ($urandom_range(0, 99) < 12) ? cfp_pkg::CH_POINT
                                          : 8'($urandom_range(8'h30, 8'h39));
      1: v = 8'($urandom_range(0, 8'h1f));
      2: v = 8'($urandom_range(8'h80, 8'hff));
      default: begin
        v = 8'($urandom);
        while (is_special(v)) v = 8'($urandom);
      end
    endcase
    return v;
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) byte_queue.push_back(s[i]);
  endfunction

  function automatic logic [7:0] pick_start();
    case ($urandom_range(0, 2))
      0: return cfp_pkg::CH_DOLLAR;
      1: return cfp_pkg::CH_PERCENT;
      default: return cfp_pkg::CH_AMP;
    endcase
  endfunction

  // One random sequence: mostly well-formed frames, some broken ones and noise
  function automatic void queue_random_sequence();
    int r, sel, len, flavor;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      byte_queue.push_back(pick_start());
      sel = $urandom_range(0, 9);
      if (sel == 7) begin
        // early end right after the start byte
        byte_queue.push_back(cfp_pkg::CH_HASH);
        return;
      end
      if (sel <= 2) byte_queue.push_back(cfp_pkg::CH_C);
      else if (sel <= 4) byte_queue.push_back(cfp_pkg::CH_U);
      else if (sel <= 6) byte_queue.push_back(cfp_pkg::CH_D);
      else byte_queue.push_back(body_byte(3));
      sel = $urandom_range(0, 99);
      if (sel < 80) len = $urandom_range(0, 8);
      else if (sel < 97) len = $urandom_range(9, 14);
      else len = $urandom_range(74, 80);   // straddles the frame limit
      sel = $urandom_range(0, 9);
      if (sel <= 5) flavor = 0;
      else if (sel == 6) flavor = 1;
      else if (sel == 7) flavor = 2;
      else flavor = 3;
      for (int i = 0; i < len; i++) byte_queue.push_back(body_byte(flavor));
      byte_queue.push_back(cfp_pkg::CH_HASH);
    end else if (r < 80) begin
      // frame cut short by the next start byte
      byte_queue.push_back(pick_start());
      len = $urandom_range(0, 5);
      for (int i = 0; i < len; i++) byte_queue.push_back(body_byte(3));
    end else if (r < 96) begin
      // raw noise, any value
      len = $urandom_range(1, 6);
      for (int i = 0; i < len; i++) byte_queue.push_back(8'($urandom));
    end else begin
      // overlong frame, dropped by the byte counter
      byte_queue.push_back(pick_start());
      len = $urandom_range(80, 90);
      flavor = $urandom_range(0, 1) * 3;
      for (int i = 0; i < len; i++) byte_queue.push_back(body_byte(flavor));
      byte_queue.push_back(cfp_pkg::CH_HASH);
    end
  endfunction

  // Offer one word, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] b);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_rx_byte(b);
    sent_count++;
  endtask

  task automatic send_queued();
    while (byte_queue.size() != 0) send_byte(byte_queue.pop_front());
  endtask

  initial begin
    int phase_len;
    sb = new(FRAME_LIMIT);
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: stray end, early end, count, down angle, byte extremes, restart
    byte_queue.push_back(cfp_pkg::CH_HASH);
    push_text("%#");
    push_text("$c9#");
    push_text("&d1.5#");
    push_text("%A");
    byte_queue.push_back(8'hff);
    byte_queue.push_back(8'h00);
    byte_queue.push_back(cfp_pkg::CH_HASH);
    push_text("$c5&u2#");
    send_queued();

    // Random, in idling phases; the hold-off lands in the first one
    sent_count = 0;
    phase_len = RANDOM_BYTES / 4;
    hold_go = 1'b1;
    while (sent_count < RANDOM_BYTES) begin
      case (sent_count / phase_len)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      queue_random_sequence();
      send_queued();
    end
    s_tvalid <= 1'b0;

    // Drain, then watch a few more cycles for stray words
    while (sb.frames_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0)
      $display("command_frame_parser verification clean");
    else
      $display("command_frame_parser verification failed");
    $finish;
  end

endmodule
